// ===== rtl/irac_pkg.sv =====
// Shared types and constants for the interval reservation admission core.
`timescale 1ns / 1ps

package irac_pkg;

    localparam int AMT_W  = 31;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 32;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_RESERVE = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        STAT_LOADED  = 2'd0,
        STAT_GRANTED = 2'd1,
        STAT_REFUSED = 2'd2,
        STAT_FROZEN  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_FROZEN
    } t_state;

    // Command broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic              load_en;
        logic              apply_en;
        logic [AMT_W-1:0]  amount;
        logic [SLOT_W-1:0] first;
        logic [SLOT_W-1:0] last;
    } t_cell_cmd;

endpackage

// ===== rtl/irac_if.sv =====
// Request and response channel interfaces for the reservation admission core.
`timescale 1ns / 1ps

interface irac_req_if import irac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [AMT_W-1:0]  amount;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] last_slot;

    modport source (output valid, req_type, amount, first_slot, last_slot, input ready);
    modport sink   (input valid, req_type, amount, first_slot, last_slot, output ready);
endinterface

interface irac_rsp_if import irac_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [CNT_W-1:0] failed_request;

    modport source (output valid, status, failed_request, input ready);
    modport sink   (input valid, status, failed_request, output ready);
endinterface

// ===== rtl/irac_cell.sv =====
// One slot cell: holds a remaining-capacity count and forwards the shortfall flag.
`timescale 1ns / 1ps

module irac_cell import irac_pkg::*; #(
    parameter int IDX_W    = 10,
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_fail,
    output logic      o_fail
);

    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

    logic [CNT_W-1:0] r_count;
    logic             r_fail;
    logic             w_hit;
    logic             w_in_range;
    logic             w_short;

    assign w_hit      = (CMP_W'(i_cmd.first) == MY_IDX);
    assign w_in_range = (CMP_W'(i_cmd.first) <= MY_IDX) && (MY_IDX <= CMP_W'(i_cmd.last));
    assign w_short    = w_in_range && (r_count < CNT_W'(i_cmd.amount));

    // Slot count: load on an address match, take the amount off when a grant applies
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && w_hit) begin
            r_count <= CNT_W'(i_cmd.amount);
        end else if (i_cmd.apply_en && w_in_range) begin
            r_count <= r_count - CNT_W'(i_cmd.amount);
        end
    end

    // Merge own shortfall into the flag from the upstream neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else begin
            r_fail <= i_fail | w_short;
        end
    end

    assign o_fail = r_fail;

endmodule

// ===== rtl/interval_reservation_admission_core.sv =====
// Order: a load or a frozen reserve is answered from the ST_LOAD or ST_FROZEN state; a reserve
// that is evaluated is answered from ST_CHECK once the sweep counter has let the shortfall flag
// ripple through the chain of slot cells, one cell per clock. Each waits for a free result slot.
// Flow: one item at a time; a new request is taken only once the last result has been registered.
// Reset (i_rst_n low, synchronous): clears the sequencer, request and failure counters
// and the result valid flag; slot counts are not cleared and hold nothing until loaded.
`timescale 1ns / 1ps

module interval_reservation_admission_core import irac_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irac_req_if.sink      i_req,
    irac_rsp_if.source    o_rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SWP_W = $clog2(SLOTS + 1);
    localparam logic [SWP_W-1:0] SWEEP_DONE = SWP_W'(SLOTS);

    // Sequencer and counters
    t_state            r_state, n_state;
    logic [SWP_W-1:0]  r_sweep, n_sweep;
    logic [CNT_W-1:0]  r_req_count, n_req_count;
    logic [CNT_W-1:0]  r_first_fail, n_first_fail;

    // Held request beat, broadcast to the cells
    logic [AMT_W-1:0]  r_amount;
    logic [SLOT_W-1:0] r_first;
    logic [SLOT_W-1:0] r_last;

    // Result register: parts the cell chain from the response channel
    logic              r_rsp_valid, n_rsp_valid;
    t_status           r_rsp_status, n_rsp_status;
    logic [CNT_W-1:0]  r_rsp_failed, n_rsp_failed;

    logic              w_accept;
    logic              w_emit;
    logic              w_free;
    logic              w_load_en;
    logic              w_apply_en;
    t_cell_cmd         w_cmd;
    logic [SLOTS:0]    w_chain;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && (r_state == ST_IDLE);
    // Result slot is free when empty or being drained this cycle
    assign w_free      = !r_rsp_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_req_count  = r_req_count;
        n_first_fail = r_first_fail;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_status = r_rsp_status;
        n_rsp_failed = r_rsp_failed;
        w_emit       = 1'b0;
        w_load_en    = 1'b0;
        w_apply_en   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_LOAD) begin
                        n_state = ST_LOAD;
                    end else if (r_first_fail != '0) begin
                        // Earlier refusal latched: answer without touching any slot
                        n_state = ST_FROZEN;
                    end else begin
                        n_state = ST_CHECK;
                        n_sweep = '0;
                        if (r_req_count != CNT_MAX) begin
                            n_req_count = r_req_count + CNT_W'(1);
                        end
                    end
                end
            end
            ST_LOAD: begin
                if (w_free) begin
                    w_load_en    = 1'b1;
                    w_emit       = 1'b1;
                    n_rsp_status = STAT_LOADED;
                    n_rsp_failed = r_first_fail;
                    n_state      = ST_IDLE;
                end
            end
            ST_FROZEN: begin
                if (w_free) begin
                    w_emit       = 1'b1;
                    n_rsp_status = STAT_FROZEN;
                    n_rsp_failed = r_first_fail;
                    n_state      = ST_IDLE;
                end
            end
            ST_CHECK: begin
                // Advance until the flag has crossed every cell, then decide
                if (r_sweep != SWEEP_DONE) begin
                    n_sweep = r_sweep + SWP_W'(1);
                end else if (w_free) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                    if (w_chain[SLOTS]) begin
                        n_first_fail = r_req_count;
                        n_rsp_status = STAT_REFUSED;
                        n_rsp_failed = r_req_count;
                    end else begin
                        w_apply_en   = 1'b1;
                        n_rsp_status = STAT_GRANTED;
                        n_rsp_failed = r_first_fail;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit) begin
            n_rsp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sweep      <= '0;
            r_req_count  <= '0;
            r_first_fail <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_req_count  <= n_req_count;
            r_first_fail <= n_first_fail;
            r_rsp_valid  <= n_rsp_valid;
        end
    end

    // Payload registers: hold the request beat and the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_amount <= i_req.amount;
            r_first  <= i_req.first_slot;
            r_last   <= i_req.last_slot;
        end
        if (w_emit) begin
            r_rsp_status <= n_rsp_status;
            r_rsp_failed <= n_rsp_failed;
        end
    end

    assign w_cmd.load_en  = w_load_en;
    assign w_cmd.apply_en = w_apply_en;
    assign w_cmd.amount   = r_amount;
    assign w_cmd.first    = r_first;
    assign w_cmd.last     = r_last;

    // Chain of slot cells; the head sees no shortfall, the tail gives the verdict
    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        irac_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_fail  (w_chain[g]),
            .o_fail  (w_chain[g+1])
        );
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_rsp_status;
    assign o_rsp.failed_request = r_rsp_failed;

`ifndef SYNTHESIS
    // A latched failure number never changes afterwards
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first_fail != '0) |=> $stable(r_first_fail))
        else $error("first failure number changed after latching");

    // A refused beat always names a failing request
    a_refused_named: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_REFUSED) |-> (o_rsp.failed_request != '0))
        else $error("refused result without failure number");

    // A frozen beat only follows a latched failure
    a_frozen_named: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_FROZEN) |-> (o_rsp.failed_request != '0))
        else $error("frozen result without failure number");

    // Failure is latched only at the end of a full sweep
    a_fail_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_first_fail != '0) |-> ($past(r_state) == ST_CHECK
            && $past(r_sweep) == SWEEP_DONE))
        else $error("failure latched outside a completed sweep");
`endif

endmodule
